// ===== rtl/deadline_timer_queue_assert.svh =====
// Assertion macros for the checker file.
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH

// The condition c must hold in the same cycle as a.
`define DTQ_ASSERT_NOW(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("deadline_timer_queue: same-cycle check failed");

// The condition c must hold in the cycle after a.
`define DTQ_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("deadline_timer_queue: next-cycle check failed");

`endif

// ===== rtl/dtq_pkg.sv =====
`timescale 1ns / 1ps
package dtq_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int RAM_W = 81;
  localparam logic [31:0] DEFAULT_WINDOW = 32'd3600000;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ACT_ADD     = 3'd0,
    ACT_CANCEL  = 3'd1,
    ACT_REFRESH = 3'd2,
    ACT_RESET   = 3'd3,
    ACT_QUERY   = 3'd4,
    ACT_EXPIRE  = 3'd5
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             idle;
    logic             accept;
    logic             decode;
    logic             rd;
    logic             scan;
    logic             emit;
    logic             load;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t act;
    logic    full;
    logic    any_act;
    logic    rd_skip;
    logic    due_any;
    logic    res_last;
    logic    out_free;
  } stat_t;

  // Deadline sum that saturates at the top of the 48-bit range.
  function automatic logic [47:0] sat_add48(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

endpackage

// ===== rtl/deadline_timer_queue.sv =====
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// in        in_valid / in_stall   action, now_ms, timer_id, period_ms, recurring, rebase_now
// out       out_valid / out_stall status, timer_id_res, remaining_ms, no_timer,
//                                 front_notify, fired, has_timer, last
// cfg       cfg_we                cfg_data (rollover_window_ms)
//
// One request at a time. Add, query_next and expire walk the slot memory one slot a cycle
// and then load their result; a reset that moves the deadline reads its slot first and
// then walks the slots. Cancel, refresh and refused requests do not walk the slots; the
// block goes back to idle before it takes the next request.
// Expire walks the slots once more for each fired timer, one search per result.
// Reset is synchronous; the slot memory is not cleared, only the active bits.
// A stalled output holds the block in its result step; in_stall is high while busy.
module deadline_timer_queue
  import dtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [47:0] now_ms,
  input  logic [3:0]  timer_id,
  input  logic [31:0] period_ms,
  input  logic        recurring,
  input  logic        rebase_now,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [3:0]  timer_id_res,
  output logic [47:0] remaining_ms,
  output logic        no_timer,
  output logic        front_notify,
  output logic        fired,
  output logic        has_timer,
  output logic        last
);

  cmd_t  cmd;
  stat_t stat;

  assign in_stall = !cmd.idle;

  // Sequencer.
  dtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Slot store, scans and result register.
  dtq_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (action),
    .now_ms       (now_ms),
    .timer_id     (timer_id),
    .period_ms    (period_ms),
    .recurring    (recurring),
    .rebase_now   (rebase_now),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .timer_id_res (timer_id_res),
    .remaining_ms (remaining_ms),
    .no_timer     (no_timer),
    .front_notify (front_notify),
    .fired        (fired),
    .has_timer    (has_timer),
    .last         (last)
  );

endmodule

// ===== rtl/dtq_ram.sv =====
`timescale 1ns / 1ps
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dtq_ctrl.sv =====
`timescale 1ns / 1ps
module dtq_ctrl
  import dtq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_READ   = 6'b000100,
    S_SCAN   = 6'b001000,
    S_EMIT   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             cnt_last;

  assign cnt_last = (cnt == CNT_W'(NUM_SLOTS));

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.act)
          ACT_ADD:     state_next = stat.full ? S_RESULT : S_SCAN;
          ACT_REFRESH: state_next = S_READ;
          ACT_RESET:   state_next = S_READ;
          ACT_QUERY:   state_next = S_SCAN;
          ACT_EXPIRE:  state_next = stat.any_act ? S_SCAN : S_RESULT;
          default:     state_next = S_RESULT;
        endcase
      end
      S_READ: begin
        state_next = stat.rd_skip ? S_RESULT : S_SCAN;
      end
      S_SCAN: begin
        if (cnt_last) begin
          state_next = (stat.act == ACT_EXPIRE && stat.due_any) ? S_EMIT : S_RESULT;
        end
      end
      S_EMIT: begin
        if (cnt_last) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) state_next = stat.res_last ? S_IDLE : S_EMIT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register and slot counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if ((state == S_SCAN || state == S_EMIT) && !cnt_last) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd.idle   = (state == S_IDLE);
    cmd.accept = (state == S_IDLE) && in_valid;
    cmd.decode = (state == S_DECODE);
    cmd.rd     = (state == S_READ);
    cmd.scan   = (state == S_SCAN);
    cmd.emit   = (state == S_EMIT);
    cmd.load   = (state == S_RESULT) && stat.out_free;
    cmd.cnt    = cnt;
  end

endmodule

// ===== rtl/dtq_datapath.sv =====
`timescale 1ns / 1ps
module dtq_datapath
  import dtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [2:0]  action,
  input  logic [47:0] now_ms,
  input  logic [3:0]  timer_id,
  input  logic [31:0] period_ms,
  input  logic        recurring,
  input  logic        rebase_now,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [3:0]  timer_id_res,
  output logic [47:0] remaining_ms,
  output logic        no_timer,
  output logic        front_notify,
  output logic        fired,
  output logic        has_timer,
  output logic        last
);

  // Request registers.
  action_t     act_q;
  logic [47:0] now_q;
  logic [3:0]  id_q;
  logic [31:0] per_q;
  logic        rec_q;
  logic        fnow_q;

  // Slot and control state.
  logic [NUM_SLOTS-1:0] active;
  logic [NUM_SLOTS-1:0] due_vec;
  logic                 latch;
  logic [47:0]          prev_time;
  logic [31:0]          window;
  logic                 roll_q;

  // Scan state.
  logic              lead_chk;
  logic              beaten;
  logic [SLOT_W-1:0] tgt;
  logic [47:0]       tgt_dl;
  logic              mfound;
  logic [47:0]       mdl;
  logic              due_any;
  logic              emit_q;
  logic              bfound;
  logic [47:0]       bdl;
  logic [SLOT_W-1:0] bidx;

  // Pending result fields.
  logic              res_st;
  logic [SLOT_W-1:0] res_id;

  // Memory ports.
  logic              m_we;
  logic [SLOT_W-1:0] m_waddr;
  logic [RAM_W-1:0]  m_wdata;
  logic [SLOT_W-1:0] m_raddr;
  logic [RAM_W-1:0]  m_rdata;
  logic              o_we;
  logic [47:0]       o_rdata;

  // Derived signals.
  logic                 r_rec;
  logic [31:0]          r_per;
  logic [47:0]          r_dl;
  logic [SLOT_W-1:0]    free_idx;
  logic [SLOT_W-1:0]    sid;
  logic [SLOT_W-1:0]    idx;
  logic                 id_ok;
  logic                 slot_act;
  logic                 same_per;
  logic [47:0]          start;
  logic [47:0]          add_dl;
  logic [47:0]          rst_dl;
  logic [47:0]          rearm_dl;
  logic                 scan_v;
  logic                 emit_v;
  logic                 due_i;
  logic                 roll;
  logic [47:0]          rem;
  logic [NUM_SLOTS-1:0] due_rest;
  logic                 out_free;

  assign r_rec = m_rdata[80];
  assign r_per = m_rdata[79:48];
  assign r_dl  = m_rdata[47:0];

  assign sid      = SLOT_W'(id_q);
  assign id_ok    = (32'(id_q) < NUM_SLOTS);
  assign slot_act = id_ok && active[sid];
  assign idx      = SLOT_W'(cmd.cnt - CNT_W'(1));
  assign scan_v   = cmd.scan && (cmd.cnt != '0);
  assign emit_v   = cmd.emit && (cmd.cnt != '0);
  assign same_per = id_ok && (per_q == r_per) && !fnow_q;

  // Reset from the old start point, clamped at zero, or from now when rebase_now is set.
  assign start    = fnow_q ? now_q : ((r_dl >= {16'b0, r_per}) ? (r_dl - {16'b0, r_per}) : '0);
  assign add_dl   = sat_add48(now_q, per_q);
  assign rst_dl   = sat_add48(start, per_q);
  assign rearm_dl = sat_add48(now_q, r_per);

  assign roll  = (now_q < prev_time) && ((prev_time - now_q) > {16'b0, window});
  assign due_i = active[idx] && (roll_q || (r_dl <= now_q));
  assign rem   = (now_q >= mdl) ? '0 : (mdl - now_q);

  assign due_rest = due_vec & ~(NUM_SLOTS'(1) << bidx);
  assign out_free = !out_valid || !out_stall;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) free_idx = SLOT_W'(i);
    end
  end

  // Status to the controller; the due flag already counts the slot checked this cycle.
  always_comb begin
    stat.act      = act_q;
    stat.full     = &active;
    stat.any_act  = |active;
    stat.rd_skip  = (act_q == ACT_RESET) ? (same_per || !slot_act) : 1'b1;
    stat.due_any  = due_any || (scan_v && act_q == ACT_EXPIRE && due_i);
    stat.res_last = emit_q ? (due_rest == '0) : 1'b1;
    stat.out_free = out_free;
  end

  // Slot memory write and read selection.
  always_comb begin
    m_we    = 1'b0;
    m_waddr = idx;
    m_wdata = {r_rec, r_per, rearm_dl};
    if (cmd.decode && act_q == ACT_ADD && !stat.full) begin
      m_we    = 1'b1;
      m_waddr = free_idx;
      m_wdata = {rec_q, per_q, add_dl};
    end else if (cmd.rd && act_q == ACT_REFRESH && slot_act) begin
      m_we    = 1'b1;
      m_waddr = sid;
      m_wdata = {r_rec, r_per, rearm_dl};
    end else if (cmd.rd && act_q == ACT_RESET && !stat.rd_skip) begin
      m_we    = 1'b1;
      m_waddr = sid;
      m_wdata = {r_rec, per_q, rst_dl};
    end else if (scan_v && act_q == ACT_EXPIRE && due_i && r_rec) begin
      m_we    = 1'b1;
    end
    m_raddr = cmd.decode ? sid : cmd.cnt[SLOT_W-1:0];
  end

  assign o_we = scan_v && (act_q == ACT_EXPIRE);

  dtq_ram #(.WIDTH(RAM_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // Deadlines as they stood before expire re-armed them, for ordering.
  dtq_ram #(.WIDTH(48), .DEPTH(NUM_SLOTS)) u_old_ram (
    .clk   (clk),
    .we    (o_we),
    .waddr (idx),
    .wdata (r_dl),
    .raddr (cmd.cnt[SLOT_W-1:0]),
    .rdata (o_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      latch     <= 1'b0;
      prev_time <= '0;
      window    <= DEFAULT_WINDOW;
      lead_chk  <= 1'b0;
      emit_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        window <= cfg_data;
      end

      // Decode step of each request.
      if (cmd.decode) begin
        emit_q <= 1'b0;
        case (act_q)
          ACT_ADD: begin
            if (!stat.full) begin
              active[free_idx] <= 1'b1;
              lead_chk         <= 1'b1;
            end
          end
          ACT_CANCEL: begin
            if (slot_act) active[sid] <= 1'b0;
          end
          ACT_QUERY: begin
            latch <= 1'b0;
          end
          ACT_EXPIRE: begin
            if (|active) prev_time <= now_q;
          end
          default: begin
          end
        endcase
      end

      // A reset that moves the deadline checks for a new leader.
      if (cmd.rd && act_q == ACT_RESET && !stat.rd_skip) begin
        lead_chk <= 1'b1;
      end

      // Expire frees the fired slots that do not recur.
      if (scan_v && act_q == ACT_EXPIRE && due_i && !r_rec) begin
        active[idx] <= 1'b0;
      end

      if (cmd.emit) begin
        emit_q <= 1'b1;
      end

      // Output register.
      if (cmd.load) begin
        out_valid <= 1'b1;
        lead_chk  <= 1'b0;
        if (lead_chk && !beaten && !latch) latch <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q  <= action_t'(action);
      now_q  <= now_ms;
      id_q   <= timer_id;
      per_q  <= period_ms;
      rec_q  <= recurring;
      fnow_q <= rebase_now;
    end

    // Result of the decode and read steps.
    if (cmd.decode) begin
      res_st <= 1'b0;
      res_id <= '0;
      case (act_q)
        ACT_ADD: begin
          res_st <= stat.full;
          if (!stat.full) begin
            res_id <= free_idx;
            tgt    <= free_idx;
            tgt_dl <= add_dl;
          end
        end
        ACT_CANCEL: begin
          res_st <= !slot_act;
          res_id <= sid;
        end
        ACT_REFRESH, ACT_RESET, ACT_QUERY: begin
        end
        ACT_EXPIRE: begin
          roll_q <= roll;
        end
        default: begin
          res_st <= 1'b1;
        end
      endcase
    end

    if (cmd.rd) begin
      res_id <= sid;
      if (act_q == ACT_RESET) begin
        res_st <= !same_per && !slot_act;
        tgt    <= sid;
        tgt_dl <= rst_dl;
      end else begin
        res_st <= !slot_act;
      end
    end

    // Scan over all slots.
    if (cmd.scan && cmd.cnt == '0) begin
      beaten  <= 1'b0;
      mfound  <= 1'b0;
      due_any <= 1'b0;
    end
    if (scan_v) begin
      case (act_q)
        ACT_ADD, ACT_RESET: begin
          if (idx != tgt && active[idx] &&
              (r_dl < tgt_dl || (r_dl == tgt_dl && idx < tgt))) begin
            beaten <= 1'b1;
          end
        end
        ACT_QUERY: begin
          if (active[idx] && (!mfound || r_dl < mdl)) begin
            mfound <= 1'b1;
            mdl    <= r_dl;
          end
        end
        ACT_EXPIRE: begin
          due_vec[idx] <= due_i;
          if (due_i) due_any <= 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Search for the next fired timer in deadline order.
    if (cmd.emit && cmd.cnt == '0) begin
      bfound <= 1'b0;
    end
    if (emit_v && due_vec[idx] && (!bfound || o_rdata < bdl)) begin
      bfound <= 1'b1;
      bdl    <= o_rdata;
      bidx   <= idx;
    end

    // Load the output fields.
    if (cmd.load) begin
      status       <= res_st;
      timer_id_res <= emit_q ? 4'(bidx) : 4'(res_id);
      remaining_ms <= (act_q == ACT_QUERY) ? (mfound ? rem : MAX48) : '0;
      no_timer     <= (act_q == ACT_QUERY) && !mfound;
      front_notify <= lead_chk && !beaten && !latch;
      fired        <= emit_q;
      has_timer    <= |active;
      last         <= stat.res_last;
      if (emit_q) due_vec[bidx] <= 1'b0;
    end
  end

endmodule

// ===== rtl/dtq_checker.sv =====
`timescale 1ns / 1ps
`include "deadline_timer_queue_assert.svh"
module dtq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        status,
  input logic [47:0] remaining_ms,
  input logic        no_timer,
  input logic        fired,
  input logic        has_timer
);

  // A stalled result stays offered.
  `DTQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // The block works on one request at a time.
  `DTQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // A fired timer is never a refused result.
  `DTQ_ASSERT_NOW(a_fired_ok, out_valid && fired, !status && !no_timer)

  // An empty query reports no active timer and the all-ones distance.
  `DTQ_ASSERT_NOW(a_no_timer, out_valid && no_timer, !has_timer && (&remaining_ms))

endmodule

bind deadline_timer_queue dtq_checker u_chk (.*);

// ===== dv/tb_deadline_timer_queue.sv =====
`timescale 1ns / 1ps
module tb_deadline_timer_queue;
  import dtq_pkg::*;

  localparam logic [2:0] ACT_BAD6 = 3'd6;
  localparam logic [2:0] ACT_BAD7 = 3'd7;

  typedef struct packed {
    logic [2:0]  act;
    logic [47:0] now;
    logic [3:0]  id;
    logic [31:0] period;
    logic        rec;
    logic        fnow;
  } request_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  id;
    logic [47:0] rem;
    logic        no_tmr;
    logic        front;
    logic        fire;
    logic        has;
    logic        lst;
  } timer_result_t;

  typedef struct packed {
    request_t      r;
    logic          typed;
    timer_result_t e;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  action = '0;
  logic [47:0] now_ms = '0;
  logic [3:0]  timer_id = '0;
  logic [31:0] period_ms = '0;
  logic        recurring = 1'b0;
  logic        rebase_now = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;
  logic [3:0]  timer_id_res;
  logic [47:0] remaining_ms;
  logic        no_timer;
  logic        front_notify;
  logic        fired;
  logic        has_timer;
  logic        last;

  deadline_timer_queue dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .now_ms(now_ms), .timer_id(timer_id), .period_ms(period_ms),
    .recurring(recurring), .rebase_now(rebase_now),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .timer_id_res(timer_id_res), .remaining_ms(remaining_ms),
    .no_timer(no_timer), .front_notify(front_notify), .fired(fired),
    .has_timer(has_timer), .last(last)
  );

  // Shadow copy of the timer store.
  logic        sh_active [NUM_SLOTS];
  logic        sh_rec [NUM_SLOTS];
  logic [31:0] sh_period [NUM_SLOTS];
  logic [47:0] sh_deadline [NUM_SLOTS];
  logic        sh_written [NUM_SLOTS];
  logic        sh_latch;
  logic [47:0] sh_prev_time;
  logic [31:0] sh_window;

  timer_result_t pending_results [$];
  stim_row_t     directed_rows [$];
  int            fail_count = 0;
  int            snd_idle = 0;
  int            rcv_idle = 0;
  logic [47:0]   cur_time = '0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [47:0] deadline_sum(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic logic store_busy();
    for (int i = 0; i < NUM_SLOTS; i++)
      if (sh_active[i]) return 1'b1;
    return 1'b0;
  endfunction

  // Earliest active slot, lowest index on a tie; -1 when empty.
  function automatic int leading_slot();
    int best;
    best = -1;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (sh_active[i] && (best < 0 || sh_deadline[i] < sh_deadline[best])) best = i;
    return best;
  endfunction

  function automatic logic take_front(int slot);
    if (leading_slot() == slot && !sh_latch) begin
      sh_latch = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Queue one expected result behind the ones already waiting.
  task automatic expect_result(input timer_result_t e);
    pending_results.insert(pending_results.size(), e);
  endtask

  // Work out the results of one accepted request and update the shadow store.
  task automatic predict_timer_step(input request_t r);
    int          s;
    int          n;
    int          b;
    logic        ok;
    logic        roll;
    logic        fn;
    logic        due [NUM_SLOTS];
    logic [47:0] dl [NUM_SLOTS];
    logic [47:0] start;
    logic [47:0] d;
    s = r.id;
    case (r.act)
      ACT_ADD: begin
        b = -1;
        for (int i = 0; i < NUM_SLOTS && b < 0; i++)
          if (!sh_active[i]) b = i;
        if (b < 0) begin
          expect_result('{1'b1, 4'd0, 48'd0, 1'b0, 1'b0, 1'b0, store_busy(), 1'b1});
        end else begin
          sh_active[b] = 1'b1;
          sh_rec[b] = r.rec;
          sh_period[b] = r.period;
          sh_written[b] = 1'b1;
          sh_deadline[b] = deadline_sum(r.now, r.period);
          fn = take_front(b);
          expect_result('{1'b0, 4'(b), 48'd0, 1'b0, fn, 1'b0, 1'b1, 1'b1});
        end
      end
      ACT_CANCEL: begin
        ok = sh_active[s];
        if (ok) sh_active[s] = 1'b0;
        expect_result('{!ok, r.id, 48'd0, 1'b0, 1'b0, 1'b0, store_busy(), 1'b1});
      end
      ACT_REFRESH: begin
        ok = sh_active[s];
        if (ok) sh_deadline[s] = deadline_sum(r.now, sh_period[s]);
        expect_result('{!ok, r.id, 48'd0, 1'b0, 1'b0, 1'b0, store_busy(), 1'b1});
      end
      ACT_RESET: begin
        if (!r.fnow && r.period == sh_period[s]) begin
          expect_result('{1'b0, r.id, 48'd0, 1'b0, 1'b0, 1'b0, store_busy(), 1'b1});
        end else if (!sh_active[s]) begin
          expect_result('{1'b1, r.id, 48'd0, 1'b0, 1'b0, 1'b0, store_busy(), 1'b1});
        end else begin
          if (r.fnow) start = r.now;
          else if (sh_deadline[s] >= {16'd0, sh_period[s]}) start = sh_deadline[s] - sh_period[s];
          else start = '0;
          sh_period[s] = r.period;
          sh_deadline[s] = deadline_sum(start, r.period);
          fn = take_front(s);
          expect_result('{1'b0, r.id, 48'd0, 1'b0, fn, 1'b0, 1'b1, 1'b1});
        end
      end
      ACT_QUERY: begin
        sh_latch = 1'b0;
        b = leading_slot();
        if (b < 0) begin
          expect_result('{1'b0, 4'd0, MAX48, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1});
        end else begin
          d = sh_deadline[b];
          expect_result('{1'b0, 4'd0, (r.now >= d) ? 48'd0 : d - r.now,
                          1'b0, 1'b0, 1'b0, 1'b1, 1'b1});
        end
      end
      ACT_EXPIRE: begin
        if (!store_busy()) begin
          expect_result('{1'b0, 4'd0, 48'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
        end else begin
          roll = (r.now < sh_prev_time) && (sh_prev_time - r.now > {16'd0, sh_window});
          sh_prev_time = r.now;
          n = 0;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            due[i] = sh_active[i] && (roll || sh_deadline[i] <= r.now);
            dl[i] = sh_deadline[i];
            if (due[i]) begin
              n++;
              if (sh_rec[i]) sh_deadline[i] = deadline_sum(r.now, sh_period[i]);
              else sh_active[i] = 1'b0;
            end
          end
          if (n == 0) begin
            expect_result('{1'b0, 4'd0, 48'd0, 1'b0, 1'b0, 1'b0, store_busy(), 1'b1});
          end
          // Fired timers go out in deadline order, lowest slot first on a tie.
          for (int k = 0; k < n; k++) begin
            b = -1;
            for (int i = 0; i < NUM_SLOTS; i++)
              if (due[i] && (b < 0 || dl[i] < dl[b])) b = i;
            due[b] = 1'b0;
            expect_result('{1'b0, 4'(b), 48'd0, 1'b0, 1'b0, 1'b1, store_busy(), k == n - 1});
          end
        end
      end
      default: begin
        expect_result('{1'b1, 4'd0, 48'd0, 1'b0, 1'b0, 1'b0, store_busy(), 1'b1});
      end
    endcase
  endtask

  // Offer one request, hold it until it is taken, then predict its results.
  task automatic send_request(input request_t r, input logic typed, input timer_result_t e);
    // A reset that compares against a period never written is not allowed.
    if (r.act == ACT_RESET && !r.fnow && !sh_written[r.id]) r.fnow = 1'b1;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= r.act;
    now_ms     <= r.now;
    timer_id   <= r.id;
    period_ms  <= r.period;
    recurring  <= r.rec;
    rebase_now <= r.fnow;
    do @(posedge clk); while (in_stall);
    predict_timer_step(r);
    if (typed) begin
      pending_results[pending_results.size() - 1] = e;
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [31:0] v);
    in_valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sh_window = v;
  endtask

  task automatic add_row(input logic [2:0] a, input logic [47:0] t, input logic [3:0] id,
                         input logic [31:0] p, input logic rc, input logic fnw);
    directed_rows.insert(directed_rows.size(), '{'{a, t, id, p, rc, fnw}, 1'b0, '0});
  endtask

  task automatic add_typed_row(input logic [2:0] a, input logic [47:0] t,
                               input logic [3:0] id, input timer_result_t e);
    directed_rows.insert(directed_rows.size(), '{'{a, t, id, 32'd0, 1'b0, 1'b0}, 1'b1, e});
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) r.act = ACT_ADD;
    else if (pick < 50) r.act = ACT_EXPIRE;
    else if (pick < 60) r.act = ACT_QUERY;
    else if (pick < 70) r.act = ACT_CANCEL;
    else if (pick < 80) r.act = ACT_REFRESH;
    else if (pick < 95) r.act = ACT_RESET;
    else r.act = ($urandom_range(1)) ? ACT_BAD6 : ACT_BAD7;
    // Time mostly moves forward; now and then it steps back or jumps anywhere.
    pick = $urandom_range(99);
    if (pick < 6) cur_time = (cur_time > 48'd5000000) ?
                             cur_time - 48'($urandom_range(5000000)) : '0;
    else if (pick < 9) cur_time = 48'({$urandom, $urandom});
    else cur_time = deadline_sum(cur_time, $urandom_range(200));
    r.now = cur_time;
    r.id = 4'($urandom_range(15));
    r.period = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(500));
    r.rec = 1'($urandom_range(1));
    r.fnow = 1'($urandom_range(1));
    // Reuse the current period now and then so the unchanged-reset case shows up.
    if (r.act == ACT_RESET && $urandom_range(3) == 0 && sh_written[r.id])
      r.period = sh_period[r.id];
    return r;
  endfunction

  // Output side: random stall and result checking.
  always @(posedge clk) begin
    timer_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: id %0d fired %0d", timer_id_res, fired);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.status) begin
          $error("status exp %0h got %0h", e.status, status); fail_count++;
        end
        if (timer_id_res !== e.id) begin
          $error("timer_id_res exp %0h got %0h", e.id, timer_id_res); fail_count++;
        end
        if (remaining_ms !== e.rem) begin
          $error("remaining_ms exp %0h got %0h", e.rem, remaining_ms); fail_count++;
        end
        if (no_timer !== e.no_tmr) begin
          $error("no_timer exp %0h got %0h", e.no_tmr, no_timer); fail_count++;
        end
        if (front_notify !== e.front) begin
          $error("front_notify exp %0h got %0h", e.front, front_notify); fail_count++;
        end
        if (fired !== e.fire) begin
          $error("fired exp %0h got %0h", e.fire, fired); fail_count++;
        end
        if (has_timer !== e.has) begin
          $error("has_timer exp %0h got %0h", e.has, has_timer); fail_count++;
        end
        if (last !== e.lst) begin
          $error("last exp %0h got %0h", e.lst, last); fail_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < rcv_idle);
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sh_active[i] = 1'b0;
      sh_rec[i] = 1'b0;
      sh_period[i] = '0;
      sh_deadline[i] = '0;
      sh_written[i] = 1'b0;
    end
    sh_latch = 1'b0;
    sh_prev_time = '0;
    sh_window = DEFAULT_WINDOW;

    // Directed part: empty store, refusals, extremes of time and period.
    add_typed_row(ACT_QUERY, 48'd0, 4'd0, '{1'b0, 4'd0, MAX48, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1});
    add_typed_row(ACT_EXPIRE, 48'd0, 4'd0, '{1'b0, 4'd0, 48'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
    add_typed_row(ACT_CANCEL, 48'd0, 4'd3, '{1'b1, 4'd3, 48'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
    add_typed_row(ACT_REFRESH, 48'd0, 4'd15,
                  '{1'b1, 4'd15, 48'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
    add_typed_row(ACT_BAD6, 48'd0, 4'd0, '{1'b1, 4'd0, 48'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
    add_typed_row(ACT_BAD7, MAX48, 4'd15, '{1'b1, 4'd0, 48'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
    add_row(ACT_ADD, 48'd100, 4'd0, 32'd0, 1'b1, 1'b0);
    add_row(ACT_ADD, 48'd100, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_row(ACT_ADD, MAX48, 4'd0, 32'd5, 1'b0, 1'b0);
    add_row(ACT_ADD, 48'd10, 4'd0, 32'd50, 1'b1, 1'b0);
    add_row(ACT_QUERY, 48'd20, 4'd0, 32'd0, 1'b0, 1'b0);
    add_row(ACT_RESET, 48'd30, 4'd1, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_row(ACT_RESET, 48'd30, 4'd3, 32'd7, 1'b0, 1'b0);
    add_row(ACT_RESET, 48'd200, 4'd0, 32'd1000, 1'b0, 1'b1);
    add_row(ACT_REFRESH, 48'd300, 4'd2, 32'd0, 1'b0, 1'b0);
    add_row(ACT_EXPIRE, 48'd1000, 4'd0, 32'd0, 1'b0, 1'b0);
    add_row(ACT_EXPIRE, 48'd10, 4'd0, 32'd0, 1'b0, 1'b0);
    add_row(ACT_CANCEL, 48'd20, 4'd0, 32'd0, 1'b0, 1'b0);
    add_row(ACT_QUERY, 48'd0, 4'd0, 32'd0, 1'b0, 1'b0);
    add_row(ACT_RESET, 48'd40, 4'd5, 32'd9, 1'b0, 1'b1);
    add_row(ACT_EXPIRE, MAX48, 4'd0, 32'd0, 1'b0, 1'b0);
    add_row(ACT_QUERY, MAX48, 4'd0, 32'd0, 1'b0, 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_idle = 36;
    rcv_idle = 86;
    foreach (directed_rows[i])
      send_request(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].e);

    // Random part in three idling phases, each under a different window.
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 36 : (ph == 1) ? 86 : 0;
      rcv_idle = (ph == 0) ? 86 : (ph == 1) ? 36 : 0;
      write_window((ph == 0) ? 32'd0 : (ph == 1) ? 32'hFFFF_FFFF : $urandom_range(20000));
      for (int k = 0; k < 64; k++) send_request(random_request(), 1'b0, '0);
    end
    write_window(DEFAULT_WINDOW);
    for (int k = 0; k < 10; k++) send_request(random_request(), 1'b0, '0);
    in_valid <= 1'b0;

    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
